// ===== rtl/crcs_pkg.sv =====
// Shared types, widths and coefficient helper for the Catmull-Rom curve sampler.
// Used by crcs_mac, crcs_round and catmull_rom_curve_sampler; no dependencies.
`default_nettype none
package crcs_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int MAX_STEP_SHIFT = 6;
  localparam int OUT_W          = COORD_WIDTH + 1;
  // Coefficient b reaches about 12 times a coordinate, c about 8 times.
  localparam int CW             = COORD_WIDTH + 4;
  // Numerator of one sample: coefficient sum times 2*N^3.
  localparam int ACC_W          = COORD_WIDTH + 3 * MAX_STEP_SHIFT + 6;
  localparam int J_W            = MAX_STEP_SHIFT + 1;
  localparam int S_W            = 3;
  localparam int SH_W           = $clog2(3 * MAX_STEP_SHIFT + 2);
  localparam int IN_TDATA_W     = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W    = ((2 * OUT_W + 7) / 8) * 8;
  localparam logic [S_W-1:0] STEP_SHIFT_RST = S_W'(MAX_STEP_SHIFT);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic signed [CW-1:0]          a;
    logic signed [CW-1:0]          b;
    logic signed [CW-1:0]          c;
    logic signed [COORD_WIDTH-1:0] p1;
  } coef_t;

  typedef struct packed {
    logic en;
    logic load;
  } mac_ctl_t;

  function automatic coef_t coef_calc(
    input logic signed [COORD_WIDTH-1:0] p0,
    input logic signed [COORD_WIDTH-1:0] p1,
    input logic signed [COORD_WIDTH-1:0] p2,
    input logic signed [COORD_WIDTH-1:0] p3
  );
    logic signed [CW-1:0] e0;
    logic signed [CW-1:0] e1;
    logic signed [CW-1:0] e2;
    logic signed [CW-1:0] e3;
    coef_t r;
    e0 = CW'(p0);
    e1 = CW'(p1);
    e2 = CW'(p2);
    e3 = CW'(p3);
    r.a  = e2 - e0;
    r.b  = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
    r.c  = e3 - e0 + ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2);
    r.p1 = p1;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/crcs_mac.sv =====
// Shared multiply-add unit: acc <= base * j + addend, base being c or acc.
// Depends on crcs_pkg.
`default_nettype none
module crcs_mac (
  input  wire logic                                clk,
  input  wire crcs_pkg::mac_ctl_t                  ctl,
  input  wire logic signed [crcs_pkg::CW-1:0]      c_in,
  input  wire logic        [crcs_pkg::J_W-1:0]     mul_j,
  input  wire logic signed [crcs_pkg::ACC_W-1:0]   addend,
  output logic signed      [crcs_pkg::ACC_W-1:0]   acc
);

  logic signed [crcs_pkg::ACC_W-1:0]              base;
  logic signed [crcs_pkg::ACC_W+crcs_pkg::J_W:0]  prod;
  logic signed [crcs_pkg::ACC_W-1:0]              acc_next;

  always_comb begin
    base     = ctl.load ? crcs_pkg::ACC_W'(c_in) : acc;
    prod     = base * $signed({1'b0, mul_j});
    acc_next = $signed(prod[crcs_pkg::ACC_W-1:0]) + addend;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= acc_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/crcs_round.sv =====
// Divide the sample numerator by 2*N^3 toward zero and saturate to output width.
// Depends on crcs_pkg.
`default_nettype none
module crcs_round (
  input  wire logic signed [crcs_pkg::ACC_W-1:0] num,
  input  wire logic        [crcs_pkg::SH_W-1:0]  sh,
  output logic signed      [crcs_pkg::OUT_W-1:0] val
);

  localparam logic [crcs_pkg::ACC_W-1:0] HI = crcs_pkg::ACC_W'((1 << (crcs_pkg::OUT_W - 1)) - 1);

  logic                          neg;
  logic [crcs_pkg::ACC_W-1:0]    mag;
  logic [crcs_pkg::ACC_W-1:0]    shd;
  logic                          over;
  logic [crcs_pkg::OUT_W-1:0]    q;

  always_comb begin
    neg  = num[crcs_pkg::ACC_W-1];
    mag  = neg ? (crcs_pkg::ACC_W'(0) - num) : num;
    shd  = mag >> sh;
    over = neg ? (shd > HI + crcs_pkg::ACC_W'(1)) : (shd > HI);
    if (over) begin
      q = neg ? crcs_pkg::OUT_W'(HI + crcs_pkg::ACC_W'(1)) : crcs_pkg::OUT_W'(HI);
    end else begin
      q = shd[crcs_pkg::OUT_W-1:0];
    end
    val = neg ? $signed(crcs_pkg::OUT_W'(0) - q) : $signed(q);
  end

endmodule
`default_nettype wire

// ===== rtl/catmull_rom_curve_sampler.sv =====
// Uniform Catmull-Rom curve sampler: keeps three points, samples one segment per new point.
// Points that only fill the window are taken while idle. A segment point is sampled x then
// y, three multiply-adds and a round each, on one shared unit; no new point is taken
// until its last sample is handed over, and a full output register stalls the sampler.
// Reset empties the point window, sets step_shift to 6 and drops any pending output.
// Depends on crcs_pkg, crcs_mac, crcs_round.
`default_nettype none
module catmull_rom_curve_sampler (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [crcs_pkg::S_W-1:0]           cfg_data,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [crcs_pkg::IN_TDATA_W-1:0]    s_tdata,  // point_x, point_y
  input  wire logic                               s_tuser,  // restart
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic [crcs_pkg::OUT_TDATA_W-1:0]        m_tdata,  // sample_x, sample_y, zero pad
  output logic                                    m_tlast   // last_sample
);

  localparam int CWD = crcs_pkg::COORD_WIDTH;

  crcs_pkg::state_t                    state;
  logic [crcs_pkg::S_W-1:0]            step_shift;
  logic signed [CWD-1:0]               held_x [3];
  logic signed [CWD-1:0]               held_y [3];
  logic [1:0]                          points_held;
  crcs_pkg::coef_t                     coef_x;
  crcs_pkg::coef_t                     coef_y;
  logic [crcs_pkg::S_W-1:0]            sh1;
  logic [crcs_pkg::SH_W-1:0]           sh2;
  logic [crcs_pkg::SH_W-1:0]           sh3;
  logic [crcs_pkg::J_W-1:0]            j;
  logic [crcs_pkg::J_W-1:0]            j_mask;
  logic [2:0]                          step;
  logic signed [crcs_pkg::OUT_W-1:0]   samp_x;
  logic signed [crcs_pkg::OUT_W-1:0]   out_x;
  logic signed [crcs_pkg::OUT_W-1:0]   out_y;

  logic                                s_fire;
  logic signed [CWD-1:0]               px;
  logic signed [CWD-1:0]               py;
  logic [crcs_pkg::S_W-1:0]            s_eff;
  logic [crcs_pkg::SH_W-1:0]           s_ext;
  crcs_pkg::coef_t                     cur;
  logic signed [crcs_pkg::ACC_W-1:0]   addend;
  crcs_pkg::mac_ctl_t                  mac_ctl;
  logic signed [crcs_pkg::ACC_W-1:0]   acc;
  logic signed [crcs_pkg::OUT_W-1:0]   rnd;
  logic                                out_free;
  logic                                run;
  logic [1:0]                          phase;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == crcs_pkg::ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;
  assign px        = $signed(s_tdata[CWD-1:0]);
  assign py        = $signed(s_tdata[2*CWD-1:CWD]);
  assign s_eff     = (step_shift > crcs_pkg::S_W'(crcs_pkg::MAX_STEP_SHIFT)) ?
                     crcs_pkg::S_W'(crcs_pkg::MAX_STEP_SHIFT) : step_shift;
  assign s_ext     = crcs_pkg::SH_W'(s_eff);
  assign run       = (state == crcs_pkg::ST_RUN);
  assign phase     = step[1:0];
  assign out_free  = !m_tvalid || m_tready;
  assign cur       = step[2] ? coef_y : coef_x;

  always_comb begin
    case (phase)
      2'd0:    addend = crcs_pkg::ACC_W'(cur.b) <<< sh1;
      2'd1:    addend = crcs_pkg::ACC_W'(cur.a) <<< sh2;
      default: addend = crcs_pkg::ACC_W'(cur.p1) <<< sh3;
    endcase
    mac_ctl.en   = run && (phase != 2'd3);
    mac_ctl.load = (phase == 2'd0);
  end

  crcs_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .c_in   (cur.c),
    .mul_j  (j),
    .addend (addend),
    .acc    (acc)
  );

  crcs_round u_round (
    .num (acc),
    .sh  (sh3),
    .val (rnd)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_shift <= crcs_pkg::STEP_SHIFT_RST;
    end else if (cfg_valid && cfg_ready) begin
      step_shift <= cfg_data;
    end
  end

  // Point window and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= crcs_pkg::ST_IDLE;
      points_held <= 2'd0;
      held_x      <= '{default: '0};
      held_y      <= '{default: '0};
      step        <= 3'd0;
      j           <= '0;
    end else begin
      unique case (state)
        crcs_pkg::ST_IDLE: begin
          if (s_fire) begin
            if (s_tuser) begin
              held_x[0]   <= px;
              held_y[0]   <= py;
              points_held <= 2'd1;
            end else if (points_held != 2'd3) begin
              case (points_held)
                2'd0: begin
                  held_x[0] <= px;
                  held_y[0] <= py;
                end
                2'd1: begin
                  held_x[1] <= px;
                  held_y[1] <= py;
                end
                default: begin
                  held_x[2] <= px;
                  held_y[2] <= py;
                end
              endcase
              points_held <= points_held + 2'd1;
            end else begin
              held_x[0] <= held_x[1];
              held_x[1] <= held_x[2];
              held_x[2] <= px;
              held_y[0] <= held_y[1];
              held_y[1] <= held_y[2];
              held_y[2] <= py;
              step      <= 3'd0;
              j         <= '0;
              state     <= crcs_pkg::ST_RUN;
            end
          end
        end
        crcs_pkg::ST_RUN: begin
          if (phase != 2'd3 || !step[2]) begin
            step <= step + 3'd1;
          end else if (out_free) begin
            // y rounded and x held: hand the sample over
            step <= 3'd0;
            if (j == j_mask) begin
              state <= crcs_pkg::ST_IDLE;
            end else begin
              j <= j + crcs_pkg::J_W'(1);
            end
          end
        end
        default: state <= crcs_pkg::ST_IDLE;
      endcase
    end
  end

  // Segment setup, latched with every accepted point and used by the point that opens a segment
  always_ff @(posedge clk) begin
    if (s_fire) begin
      coef_x <= crcs_pkg::coef_calc(held_x[0], held_x[1], held_x[2], px);
      coef_y <= crcs_pkg::coef_calc(held_y[0], held_y[1], held_y[2], py);
      sh1    <= s_eff;
      sh2    <= s_ext << 1;
      sh3    <= (s_ext << 1) + s_ext + crcs_pkg::SH_W'(1);
      j_mask <= ~({crcs_pkg::J_W{1'b1}} << s_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (run && phase == 2'd3 && !step[2]) begin
      samp_x <= rnd;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (run && phase == 2'd3 && step[2] && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (run && phase == 2'd3 && step[2] && out_free) begin
      out_x   <= samp_x;
      out_y   <= rnd;
      m_tlast <= (j == j_mask);
    end
  end

  assign m_tdata = crcs_pkg::OUT_TDATA_W'({out_y, out_x});

endmodule
`default_nettype wire
